[hdl/pwsf_pkg.sv]
package pwsf_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int GAIN_W      = 16;
    localparam int ISUM_W      = 32;
    localparam int ILIM_W      = 31;
    localparam int PLIM_W      = 16;
    localparam int DRIVE_W     = 16;
    localparam int FF_LIMIT    = 500;
    localparam int EF_W        = 10;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST = 16'sh8000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST = 16'sh7fff;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P     = 8'd0,
        REG_GAIN_I     = 8'd1,
        REG_GAIN_D     = 8'd2,
        REG_GAIN_F     = 8'd3,
        REG_ILIMIT     = 8'd4,
        REG_PLIMIT     = 8'd5,
        REG_DRIVE_MIN  = 8'd6,
        REG_DRIVE_MAX  = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  gain_f;
        logic [ILIM_W-1:0]  integral_limit;
        logic [PLIM_W-1:0]  proportional_limit;
        logic [DRIVE_W-1:0] drive_min;
        logic [DRIVE_W-1:0] drive_max;
    } cfg_t;

endpackage

[hdl/pwsf_if.sv]
interface pwsf_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pwsf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pwsf_pkg::DRIVE_W-1:0]    drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface pwsf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pwsf_pkg::CFG_INDEX_W-1:0]  index;
    logic [pwsf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/pwsf_cfg_regs.sv]
module pwsf_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    pwsf_cfg_if.sink       cfg,
    output pwsf_pkg::cfg_t regs
);

    pwsf_pkg::cfg_t cfg_reg;
    pwsf_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (pwsf_pkg::cfg_reg_t'(cfg.index))
                pwsf_pkg::REG_GAIN_P:
                    cfg_next.gain_p = cfg.data[pwsf_pkg::GAIN_W-1:0];
                pwsf_pkg::REG_GAIN_I:
                    cfg_next.gain_i = cfg.data[pwsf_pkg::GAIN_W-1:0];
                pwsf_pkg::REG_GAIN_D:
                    cfg_next.gain_d = cfg.data[pwsf_pkg::GAIN_W-1:0];
                pwsf_pkg::REG_GAIN_F:
                    cfg_next.gain_f = cfg.data[pwsf_pkg::GAIN_W-1:0];
                pwsf_pkg::REG_ILIMIT:
                    cfg_next.integral_limit = cfg.data[pwsf_pkg::ILIM_W-1:0];
                pwsf_pkg::REG_PLIMIT:
                    cfg_next.proportional_limit = cfg.data[pwsf_pkg::PLIM_W-1:0];
                pwsf_pkg::REG_DRIVE_MIN:
                    cfg_next.drive_min = cfg.data[pwsf_pkg::DRIVE_W-1:0];
                pwsf_pkg::REG_DRIVE_MAX:
                    cfg_next.drive_max = cfg.data[pwsf_pkg::DRIVE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                gain_p:             '0,
                gain_i:             '0,
                gain_d:             '0,
                gain_f:             '0,
                integral_limit:     '0,
                proportional_limit: '0,
                drive_min:          pwsf_pkg::DRIVE_MIN_RST,
                drive_max:          pwsf_pkg::DRIVE_MAX_RST
            };
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/pwsf_datapath.sv]
module pwsf_datapath #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  pwsf_pkg::cfg_t                          cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]          target,
    input  logic signed [SAMPLE_WIDTH-1:0]          measured,
    input  logic signed [SAMPLE_WIDTH-1:0]          prev_target,
    input  logic signed [SAMPLE_WIDTH-1:0]          prev_measured,
    input  logic signed [pwsf_pkg::ISUM_W-1:0]      isum,
    output logic signed [pwsf_pkg::ISUM_W-1:0]      isum_new,
    output logic signed [pwsf_pkg::DRIVE_W-1:0]     drive
);

    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int SW = ((EW > pwsf_pkg::ISUM_W) ? EW : pwsf_pkg::ISUM_W) + 1;
    localparam int CW = ((EW > pwsf_pkg::PLIM_W + 1) ? EW : pwsf_pkg::PLIM_W + 1) + 1;
    localparam int DW = (EW > pwsf_pkg::EF_W + 1) ? EW : pwsf_pkg::EF_W + 1;
    localparam int GW = pwsf_pkg::GAIN_W;
    localparam int PW = GW + CW;
    localparam int IW = GW + pwsf_pkg::ISUM_W;
    localparam int QW = GW + EW;
    localparam int FW = GW + pwsf_pkg::EF_W;
    localparam int AW = ((IW > PW) ? IW : PW) + 2;

    localparam logic signed [SW-1:0] I32_MAX = SW'(64'sh7fffffff);
    localparam logic signed [SW-1:0] I32_MIN = ~I32_MAX;
    localparam logic signed [DW-1:0] FF_POS  = DW'(pwsf_pkg::FF_LIMIT);
    localparam logic signed [DW-1:0] FF_NEG  = -FF_POS;

    logic signed [EW-1:0]               err;
    logic signed [SW-1:0]               sum_w;
    logic signed [SW-1:0]               sum_sat;
    logic signed [pwsf_pkg::ISUM_W-1:0] sum_32;
    logic signed [pwsf_pkg::ISUM_W-1:0] ilim_pos;
    logic signed [pwsf_pkg::ISUM_W-1:0] ilim_neg;
    logic signed [CW-1:0]               err_c;
    logic signed [CW-1:0]               plim_pos;
    logic signed [CW-1:0]               plim_neg;
    logic signed [CW-1:0]               ep;
    logic signed [EW-1:0]               ed;
    logic signed [EW-1:0]               dt;
    logic signed [DW-1:0]               dt_c;
    logic signed [DW-1:0]               ef_c;
    logic signed [pwsf_pkg::EF_W-1:0]   ef;
    logic signed [PW-1:0]               prod_p;
    logic signed [IW-1:0]               prod_i;
    logic signed [QW-1:0]               prod_d;
    logic signed [FW-1:0]               prod_f;
    logic signed [AW-1:0]               acc;
    logic signed [AW-1:0]               acc_sh;
    logic signed [AW-1:0]               dmin_w;
    logic signed [AW-1:0]               dmax_w;

    assign err = {target[SAMPLE_WIDTH-1], target} - {measured[SAMPLE_WIDTH-1], measured};

    // integrator: saturate at 32 bits, then optional symmetric clamp
    assign sum_w   = SW'(isum) + SW'(err);
    assign sum_sat = (sum_w < I32_MIN) ? I32_MIN : ((sum_w > I32_MAX) ? I32_MAX : sum_w);
    assign sum_32  = sum_sat[pwsf_pkg::ISUM_W-1:0];
    assign ilim_pos = {1'b0, cfg.integral_limit};
    assign ilim_neg = -ilim_pos;

    always_comb
    begin
        if (cfg.integral_limit == '0)
            isum_new = sum_32;
        else if (sum_32 < ilim_neg)
            isum_new = ilim_neg;
        else if (sum_32 > ilim_pos)
            isum_new = ilim_pos;
        else
            isum_new = sum_32;
    end

    assign err_c    = CW'(err);
    assign plim_pos = CW'({1'b0, cfg.proportional_limit});
    assign plim_neg = -plim_pos;

    always_comb
    begin
        if (cfg.proportional_limit == '0)
            ep = err_c;
        else if (err_c < plim_neg)
            ep = plim_neg;
        else if (err_c > plim_pos)
            ep = plim_pos;
        else
            ep = err_c;
    end

    assign ed = {prev_measured[SAMPLE_WIDTH-1], prev_measured}
              - {measured[SAMPLE_WIDTH-1], measured};

    assign dt   = {target[SAMPLE_WIDTH-1], target}
                - {prev_target[SAMPLE_WIDTH-1], prev_target};
    assign dt_c = DW'(dt);
    assign ef_c = (dt_c < FF_NEG) ? FF_NEG : ((dt_c > FF_POS) ? FF_POS : dt_c);
    assign ef   = ef_c[pwsf_pkg::EF_W-1:0];

    assign prod_p = $signed(cfg.gain_p) * ep;
    assign prod_i = $signed(cfg.gain_i) * isum_new;
    assign prod_d = $signed(cfg.gain_d) * ed;
    assign prod_f = $signed(cfg.gain_f) * ef;

    assign acc    = AW'(prod_p) + AW'(prod_i) + AW'(prod_d) + AW'(prod_f);
    assign acc_sh = acc >>> pwsf_pkg::FRAC_BITS;   // floor

    assign dmin_w = AW'($signed(cfg.drive_min));
    assign dmax_w = AW'($signed(cfg.drive_max));

    // low bound is checked first: with inverted bounds, values below it take the low bound, all others the high bound
    always_comb
    begin
        if (acc_sh < dmin_w)
            drive = cfg.drive_min;
        else if (acc_sh > dmax_w)
            drive = cfg.drive_max;
        else
            drive = acc_sh[pwsf_pkg::DRIVE_W-1:0];
    end

endmodule

[hdl/pid_with_setpoint_feedforward.sv]
// Path: sample register, then result register. Throughput: one sample
// per cycle unless the result is held back with both registers full; the
// integrator add/saturate/clamp loop and the four gain multipliers sit
// in one combinational pass between the sample and result registers.
// Reset (rst_n, async, active low) clears gains and limits, sets drive
// bounds to full range, and zeroes the integrator and previous samples.
module pid_with_setpoint_feedforward #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    pwsf_sample_if.sink     sample,
    pwsf_result_if.source   result,
    pwsf_cfg_if.sink        cfg
);

    pwsf_pkg::cfg_t regs;

    logic                               s1_vld_reg, s1_vld_next;
    logic signed [SAMPLE_WIDTH-1:0]     s1_tgt_reg, s1_tgt_next;
    logic signed [SAMPLE_WIDTH-1:0]     s1_meas_reg, s1_meas_next;
    logic                               out_vld_reg, out_vld_next;
    logic signed [pwsf_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic signed [pwsf_pkg::ISUM_W-1:0] isum_reg, isum_next;
    logic signed [SAMPLE_WIDTH-1:0]     prev_t_reg, prev_t_next;
    logic signed [SAMPLE_WIDTH-1:0]     prev_m_reg, prev_m_next;

    logic signed [pwsf_pkg::ISUM_W-1:0] isum_new;
    logic signed [pwsf_pkg::DRIVE_W-1:0] drive_calc;
    logic                               take;
    logic                               adv;

    pwsf_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pwsf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .cfg           (regs),
        .target        (s1_tgt_reg),
        .measured      (s1_meas_reg),
        .prev_target   (prev_t_reg),
        .prev_measured (prev_m_reg),
        .isum          (isum_reg),
        .isum_new      (isum_new),
        .drive         (drive_calc)
    );

    assign adv          = s1_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !s1_vld_reg || !out_vld_reg || result.ready;
    assign take         = sample.valid && sample.ready;

    assign result.valid = out_vld_reg;
    assign result.drive = drive_reg;

    always_comb
    begin
        s1_vld_next  = take ? 1'b1 : (adv ? 1'b0 : s1_vld_reg);
        out_vld_next = adv ? 1'b1 : (result.ready ? 1'b0 : out_vld_reg);
        s1_tgt_next  = take ? sample.target : s1_tgt_reg;
        s1_meas_next = take ? sample.measured : s1_meas_reg;
        drive_next   = adv ? drive_calc : drive_reg;
        // controller state moves only when the item leaves the sample stage
        isum_next    = adv ? isum_new : isum_reg;
        prev_t_next  = adv ? s1_tgt_reg : prev_t_reg;
        prev_m_next  = adv ? s1_meas_reg : prev_m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            isum_reg    <= '0;
            prev_t_reg  <= '0;
            prev_m_reg  <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            isum_reg    <= isum_next;
            prev_t_reg  <= prev_t_next;
            prev_m_reg  <= prev_m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tgt_reg  <= s1_tgt_next;
        s1_meas_reg <= s1_meas_next;
        drive_reg   <= drive_next;
    end

endmodule

[hdl/pwsf_checker.sv]
module pwsf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [pwsf_pkg::DRIVE_W-1:0] drive,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pwsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                                in_acc;
    logic                                out_acc;
    logic                                cfg_acc;
    logic [1:0]                          cnt_reg, cnt_next;
    logic signed [pwsf_pkg::DRIVE_W-1:0] dmin_reg, dmin_next;
    logic signed [pwsf_pkg::DRIVE_W-1:0] dmax_reg, dmax_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign cfg_acc = cfg_valid && cfg_ready;

    always_comb
    begin
        cnt_next  = cnt_reg + {1'b0, in_acc} - {1'b0, out_acc};
        dmin_next = dmin_reg;
        dmax_next = dmax_reg;
        if (cfg_acc && cfg_index == pwsf_pkg::REG_DRIVE_MIN)
            dmin_next = cfg_data[pwsf_pkg::DRIVE_W-1:0];
        if (cfg_acc && cfg_index == pwsf_pkg::REG_DRIVE_MAX)
            dmax_next = cfg_data[pwsf_pkg::DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            dmin_reg <= pwsf_pkg::DRIVE_MIN_RST;
            dmax_reg <= pwsf_pkg::DRIVE_MAX_RST;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
        end
    end

    // no result without an outstanding request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result valid with no outstanding request");

    // two pipeline slots at most
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("more requests in flight than pipeline slots");

    // empty pipeline: result follows acceptance via sample and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cnt_reg == 2'd0) |=> ##1 out_valid)
        else $error("result missing two cycles after request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(drive)))
        else $error("stalled result changed");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dmin_reg <= dmax_reg) |-> (drive >= dmin_reg && drive <= dmax_reg))
        else $error("drive outside configured bounds");

endmodule

bind pid_with_setpoint_feedforward pwsf_checker u_pwsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
);

[test/tb_pid_with_setpoint_feedforward.sv]
module tb_pid_with_setpoint_feedforward;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SW         = 16;
    localparam int     CYCLE_CAP  = 1_000_000;
    localparam int     HOLD_LEN   = 400;
    localparam longint ISUM_MAX   = (longint'(1) <<< (pwsf_pkg::ISUM_W - 1)) - 1;
    localparam longint ISUM_MIN   = -(longint'(1) <<< (pwsf_pkg::ISUM_W - 1));

    typedef struct packed {
        logic signed [SW-1:0] target;
        logic signed [SW-1:0] measured;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pwsf_sample_if #(.SAMPLE_WIDTH(SW)) smp ();
    pwsf_result_if                      res ();
    pwsf_cfg_if                         cfgb ();

    pid_with_setpoint_feedforward #(.SAMPLE_WIDTH(SW)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfgb)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // controller shadow: settings plus integrator and last samples
    pwsf_pkg::cfg_t                      cfg_model;
    logic signed [pwsf_pkg::ISUM_W-1:0]  integ;
    logic signed [SW-1:0]                hist_target;
    logic signed [SW-1:0]                last_meas;

    sample_t                             pending[$];
    logic signed [pwsf_pkg::DRIVE_W-1:0] drive_expected[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   n_pushed = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_mismatch = 0;
    int   n_settings = 0;
    int   cycles = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    logic signed [SW-1:0] walk_target = '0;

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic logic signed [pwsf_pkg::DRIVE_W-1:0] predict_drive(
        logic signed [SW-1:0] tgt,
        logic signed [SW-1:0] meas);
        longint err, sum, ep, ed, ef, acc, y, lim;
        err = longint'(tgt) - longint'(meas);
        sum = clip(longint'(integ) + err, ISUM_MIN, ISUM_MAX);
        lim = longint'(cfg_model.integral_limit);
        if (lim != 0)
            sum = clip(sum, -lim, lim);
        ep = err;
        lim = longint'(cfg_model.proportional_limit);
        if (lim != 0)
            ep = clip(ep, -lim, lim);
        ed = longint'(last_meas) - longint'(meas);
        ef = clip(longint'(tgt) - longint'(hist_target),
                  -longint'(pwsf_pkg::FF_LIMIT), longint'(pwsf_pkg::FF_LIMIT));
        acc = longint'($signed(cfg_model.gain_p)) * ep
            + longint'($signed(cfg_model.gain_i)) * sum
            + longint'($signed(cfg_model.gain_d)) * ed
            + longint'($signed(cfg_model.gain_f)) * ef;
        // arithmetic shift of a signed value rounds toward minus infinity
        y = clip(acc >>> pwsf_pkg::FRAC_BITS, longint'($signed(cfg_model.drive_min)),
                 longint'($signed(cfg_model.drive_max)));
        integ = sum[pwsf_pkg::ISUM_W-1:0];
        hist_target = tgt;
        last_meas = meas;
        return y[pwsf_pkg::DRIVE_W-1:0];
    endfunction

    function automatic void apply_reg_write(logic [pwsf_pkg::CFG_INDEX_W-1:0] idx,
                                            logic [pwsf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pwsf_pkg::REG_GAIN_P:
                cfg_model.gain_p = data[pwsf_pkg::GAIN_W-1:0];
            pwsf_pkg::REG_GAIN_I:
                cfg_model.gain_i = data[pwsf_pkg::GAIN_W-1:0];
            pwsf_pkg::REG_GAIN_D:
                cfg_model.gain_d = data[pwsf_pkg::GAIN_W-1:0];
            pwsf_pkg::REG_GAIN_F:
                cfg_model.gain_f = data[pwsf_pkg::GAIN_W-1:0];
            pwsf_pkg::REG_ILIMIT:
                cfg_model.integral_limit = data[pwsf_pkg::ILIM_W-1:0];
            pwsf_pkg::REG_PLIMIT:
                cfg_model.proportional_limit = data[pwsf_pkg::PLIM_W-1:0];
            pwsf_pkg::REG_DRIVE_MIN:
                cfg_model.drive_min = data[pwsf_pkg::DRIVE_W-1:0];
            pwsf_pkg::REG_DRIVE_MAX:
                cfg_model.drive_max = data[pwsf_pkg::DRIVE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void log_mismatch(string msg);
        if (n_mismatch < 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_mismatch++;
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        sample_t nxt;
        if (!rst_n) begin
            smp.valid    <= 1'b0;
            smp.target   <= '0;
            smp.measured <= '0;
        end
        else begin
            if (smp.valid && smp.ready) begin
                drive_expected.push_back(predict_drive(smp.target, smp.measured));
                n_accepted <= n_accepted + 1;
            end
            if (!smp.valid || smp.ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending.pop_front();
                    smp.valid    <= 1'b1;
                    smp.target   <= nxt.target;
                    smp.measured <= nxt.measured;
                end
                else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(posedge clk)
    begin
        if (!rst_n) begin
            hold_left <= 0;
        end
        else if (hold_req && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        logic signed [pwsf_pkg::DRIVE_W-1:0] want;
        if (!rst_n) begin
            res.ready <= 1'b0;
        end
        else begin
            if (res.valid && res.ready) begin
                n_results <= n_results + 1;
                if (drive_expected.size() == 0) begin
                    log_mismatch($sformatf("drive %0d with no request outstanding", res.drive));
                end
                else begin
                    want = drive_expected.pop_front();
                    if (res.drive !== want)
                        log_mismatch($sformatf("drive expected %0d, got %0d", want, res.drive));
                end
            end
            res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, drive_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [pwsf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pwsf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfgb.valid <= 1'b1;
        cfgb.index <= idx;
        cfgb.data  <= data;
        do
            @(posedge clk);
        while (!cfgb.ready);
        cfgb.valid <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    // upper data bits are junk on purpose; the block must drop them
    task automatic write_reg16(logic [pwsf_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] v);
        write_reg(idx, {16'($urandom), v});
    endtask

    task automatic load_settings(int p, int i, int d, int f, int il, int pl, int lo, int hi);
        write_reg16(pwsf_pkg::REG_GAIN_P, 16'(p));
        write_reg16(pwsf_pkg::REG_GAIN_I, 16'(i));
        write_reg16(pwsf_pkg::REG_GAIN_D, 16'(d));
        write_reg16(pwsf_pkg::REG_GAIN_F, 16'(f));
        write_reg(pwsf_pkg::REG_ILIMIT, {1'($urandom), pwsf_pkg::ILIM_W'(il)});
        write_reg16(pwsf_pkg::REG_PLIMIT, 16'(pl));
        write_reg16(pwsf_pkg::REG_DRIVE_MIN, 16'(lo));
        write_reg16(pwsf_pkg::REG_DRIVE_MAX, 16'(hi));
        // unmapped index, must not disturb anything
        write_reg(pwsf_pkg::CFG_INDEX_W'($urandom_range(2 ** pwsf_pkg::CFG_INDEX_W - 1,
                                                        int'(pwsf_pkg::REG_DRIVE_MAX) + 1)),
                  $urandom);
        n_settings++;
    endtask

    task automatic push_sample(int t, int m);
        pending.push_back('{target: SW'(t), measured: SW'(m)});
        n_pushed++;
    endtask

    task automatic push_run(int n, int t, int m);
        for (int k = 0; k < n; k++)
            push_sample(t, m);
    endtask

    function automatic int extreme_value();
        case ($urandom_range(3))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // mostly a wandering setpoint with a nearby measurement, some raw noise and extremes
    task automatic queue_random(int n);
        int t, m, r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                t = int'(clip(longint'(walk_target) + longint'($urandom_range(1400)) - 700,
                              -32768, 32767));
                m = int'(clip(longint'(t) + longint'($urandom_range(600)) - 300,
                              -32768, 32767));
            end
            else if (r < 85) begin
                t = int'($signed(16'($urandom)));
                m = int'($signed(16'($urandom)));
            end
            else begin
                t = extreme_value();
                m = extreme_value();
            end
            walk_target = SW'(t);
            push_sample(t, m);
        end
    endtask

    task automatic drain();
        while (n_accepted != n_pushed || drive_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cfgb.valid    <= 1'b0;
        cfgb.index    <= '0;
        cfgb.data     <= '0;
        cfg_model = '0;
        cfg_model.drive_min = pwsf_pkg::DRIVE_MIN_RST;
        cfg_model.drive_max = pwsf_pkg::DRIVE_MAX_RST;
        integ = '0;
        hist_target = '0;
        last_meas = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct <= 17;
        recv_idle_pct <= 61;
        load_settings(256, 16, 128, 384, 0, 0, -32768, 32767);
        // first request sees zero history in derivative and feedforward
        push_sample(1000, -200);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(0, 0);
        push_sample(600, 0);
        push_sample(100, 0);
        push_sample(600, 100);
        push_sample(100, 100);
        push_sample(-1, -1);
        push_sample(32767, 32767);
        push_sample(-32768, -32768);
        push_sample(32767, 0);
        push_sample(0, -32768);
        push_sample(-32768, 0);
        push_sample(0, 32767);
        push_sample(-1, 0);
        drain();

        load_settings(200, 5, -96, 64, 100000, 0, -20000, 20000);
        queue_random(125);
        drain();

        send_idle_pct <= 61;
        recv_idle_pct <= 17;
        load_settings(32767, -32768, -32768, 32767, 32'h7fffffff, 65535, -32768, 32767);
        queue_random(125);
        drain();

        // inverted bounds: anything not below the low bound lands on the high bound
        load_settings(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                      1, 1, 150, -150);
        queue_random(125);
        drain();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        load_settings(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom_range(32'h7fffffff)), int'($urandom_range(65535)),
                      -int'($urandom_range(32768)), int'($urandom_range(32767)));
        hold_req <= 1'b1;
        queue_random(125);
        drain();

        // integrator against a tight limit: clamp high, run down into the low clamp, back up
        load_settings(0, 1, 0, 0, 200000, 0, -32768, 32767);
        push_run(8, 32767, -32768);
        push_run(12, -32768, 32767);
        push_run(6, 32767, -32768);
        drain();

        $display("%0d requests, %0d results, %0d mismatches over %0d register settings",
                 n_accepted, n_results, n_mismatch, n_settings);
        $display("incl. inverted drive bounds, receiver hold-off and integrator clamps");
        if (n_mismatch == 0 && drive_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/pwsf_pkg.sv
hdl/pwsf_if.sv
hdl/pwsf_cfg_regs.sv
hdl/pwsf_datapath.sv
hdl/pid_with_setpoint_feedforward.sv
hdl/pwsf_checker.sv
test/tb_pid_with_setpoint_feedforward.sv
